FILE: src/bmalloc_pkg.sv
// Shared constants for the bitmap address allocator.
package bmalloc_pkg;

	localparam int DEF_SLOT_COUNT = 1024;

	localparam int OP_W    = 2;
	localparam int PHYS_W  = 8;
	localparam int LOGIC_W = 11;
	localparam int TDATA_W = 24;

	localparam logic [OP_W-1:0] OP_ALLOC       = 2'd0;
	localparam logic [OP_W-1:0] OP_SLOT_TO_PHY = 2'd1;
	localparam logic [OP_W-1:0] OP_PHY_TO_SLOT = 2'd2;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef logic [PHYS_W-1:0]  phys_t;
	typedef logic [LOGIC_W-1:0] logic_addr_t;

endpackage

FILE: src/bmalloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: src/bitmap_address_allocator.sv
// Top level of the bitmap address allocator.
// Usage: one request word enters on the s_axis channel, one response word
// leaves on the m_axis channel for every request. tuser carries the opcode
// (allocate, slot to physical lookup, physical to slot lookup) on the way in
// and the status flag on the way out.
// Slots are never freed, so they are handed out in order and a fill count
// stands for the used-slot bitmap; table entries at or above the count read
// as zero without being stored, so no clearing pass follows reset.
// Path from acceptance to a valid response: allocate, an unused opcode and a
// slot lookup that is out of range or hits a slot not yet allocated go
// through EXEC and DONE; slot to physical lookup of an allocated slot goes
// through EXEC, RDWAIT and DONE; physical to slot lookup goes through EXEC,
// SCAN and DONE, the scan reading the slot table through its single read
// port, one entry per cycle, from slot 0 until a match or the fill count.
// One request is in work at a time; s_axis_tready is high only when idle, and
// the next request may be accepted once the response turns valid.
// Reset empties the table at once (count back to zero) and drops any
// pending response. When the receiver stalls, the response holds in the
// output register and the next request may be accepted and worked on, but
// its result waits until the output register is free.
module bitmap_address_allocator
	import bmalloc_pkg::*;
#(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,  // phys_addr[7:0], slot_index[18:8], zero pad
	input  logic [OP_W-1:0]    s_axis_tuser,  // opcode[1:0]
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // logic_addr[10:0], phys_result[18:11], zero pad
	output logic               m_axis_tuser   // status[0]
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOT_COUNT);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_RDWAIT = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_addr_q;
	logic               scan_vld_s1;
	logic [IDX_W-1:0]   scan_addr_s1;
	logic               out_valid_q;

	logic [OP_W-1:0]    op_q;
	phys_t              phys_q;
	logic [LOGIC_W-1:0] slot_q;
	logic               res_status_q;
	logic_addr_t        res_logic_q;
	phys_t              res_phys_q;
	logic               out_status_q;
	logic_addr_t        out_logic_q;
	phys_t              out_phys_q;

	logic               wr_en;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	phys_t              rd_data;
	logic               can_put;
	logic               slot_range_bad;
	logic               slot_unwritten;
	logic               scan_hit;
	logic               scan_end;
	logic               scan_issue;

	assign can_put        = !out_valid_q || m_axis_tready;
	assign slot_range_bad = 32'(slot_q) >= 32'(SLOT_COUNT);
	assign slot_unwritten = 32'(slot_q) >= 32'(count_q);
	assign scan_hit       = scan_vld_s1 && (rd_data == phys_q);
	assign scan_end       = !scan_vld_s1 && (scan_addr_q == count_q);
	assign scan_issue     = (state_q == ST_SCAN) && !scan_hit && (scan_addr_q != count_q);

	assign wr_en = (state_q == ST_EXEC) && (op_q == OP_ALLOC) && (count_q != FULL_COUNT);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = IDX_W'(scan_addr_q);
		if (scan_issue) begin
			rd_en = 1'b1;
		end else if ((state_q == ST_EXEC) && (op_q == OP_SLOT_TO_PHY) && !slot_range_bad
				&& !slot_unwritten) begin
			rd_en   = 1'b1;
			rd_addr = IDX_W'(slot_q);
		end
	end

	bmalloc_ram #(
		.WIDTH(PHYS_W),
		.DEPTH(SLOT_COUNT)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(IDX_W'(count_q)),
		.wr_data(phys_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_addr_q <= '0;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && can_put) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					scan_addr_q <= '0;
					scan_vld_s1 <= 1'b0;
					if (wr_en) begin
						count_q <= count_q + 1'b1;
					end
					if (op_q == OP_PHY_TO_SLOT) begin
						state_q <= ST_SCAN;
					end else if (rd_en) begin
						state_q <= ST_RDWAIT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_hit || scan_end) begin
						state_q <= ST_DONE;
					end else begin
						scan_vld_s1 <= scan_issue;
						if (scan_issue) begin
							scan_addr_q <= scan_addr_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (can_put) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q   <= s_axis_tuser;
			phys_q <= s_axis_tdata[PHYS_W-1:0];
			slot_q <= s_axis_tdata[PHYS_W +: LOGIC_W];
		end
		if (scan_issue) begin
			scan_addr_s1 <= IDX_W'(scan_addr_q);
		end
		case (state_q)
			ST_EXEC: begin
				res_phys_q <= '0;
				case (op_q)
					OP_ALLOC: begin
						if (count_q != FULL_COUNT) begin
							res_status_q <= STATUS_OK;
							res_logic_q  <= LOGIC_W'(32'(count_q) + 32'd1);
						end else begin
							res_status_q <= STATUS_FAIL;
							res_logic_q  <= '0;
						end
					end
					OP_SLOT_TO_PHY: begin
						res_status_q <= slot_range_bad ? STATUS_FAIL : STATUS_OK;
						res_logic_q  <= '0;
					end
					default: begin
						res_status_q <= STATUS_FAIL;
						res_logic_q  <= '0;
					end
				endcase
			end
			ST_RDWAIT: begin
				res_phys_q <= rd_data;
			end
			ST_SCAN: begin
				if (scan_hit) begin
					res_status_q <= STATUS_OK;
					res_logic_q  <= LOGIC_W'(scan_addr_s1);
				end else if (scan_end && (phys_q == '0) && (count_q != FULL_COUNT)) begin
					res_status_q <= STATUS_OK;
					res_logic_q  <= LOGIC_W'(count_q);
				end
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
		if ((state_q == ST_DONE) && can_put) begin
			out_status_q <= res_status_q;
			out_logic_q  <= res_logic_q;
			out_phys_q   <= res_phys_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {(TDATA_W - LOGIC_W - PHYS_W)'(0), out_phys_q, out_logic_q};

endmodule
